### sv/fre_pkg.sv
package fre_pkg;

    localparam int MEDIAN_W    = 12;
    localparam int STRIP_W     = 4;
    localparam int BYTE_W      = 8;
    localparam int VAL_W       = 17;
    localparam int FIB_N       = 24;
    localparam int CODE_W      = 24;
    localparam int LEN_W       = 5;
    localparam int ACC_W       = 31;
    localparam int CNT_W       = 5;
    localparam int SCAN_LANES  = 8;
    localparam int SCAN_PASSES = 3;
    localparam int PASS_W      = 2;
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;

    localparam logic REG_MEDIAN = 1'b0;
    localparam logic REG_STRIP  = 1'b1;

    localparam logic [VAL_W-1:0] FIB_WEIGHT [FIB_N] = '{
        17'd1,     17'd2,     17'd3,     17'd5,     17'd8,     17'd13,
        17'd21,    17'd34,    17'd55,    17'd89,    17'd144,   17'd233,
        17'd377,   17'd610,   17'd987,   17'd1597,  17'd2584,  17'd4181,
        17'd6765,  17'd10946, 17'd17711, 17'd28657, 17'd46368, 17'd75025
    };

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
        logic              flush;
    } fre_cw_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } fre_out_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_SCAN,
        F_SEND
    } front_state_t;

    typedef enum logic {
        B_LOAD,
        B_EMIT
    } back_state_t;

endpackage

### sv/fre_fifo.sv
module fre_fifo #(
    parameter int WIDTH = 8,
    parameter int AW    = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int DEPTH = 1 << AW;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW:0]      count_reg;
    logic [AW:0]      count_next;
    logic             do_wr;
    logic             do_rd;

    assign full  = (count_reg == (AW+1)'(DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;
    assign dout  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

### sv/fre_front.sv
module fre_front #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [SAMPLE_BITS-1:0]          sample,
    input  logic                            flush,
    input  logic                            push,
    output logic                            full,
    input  logic [fre_pkg::MEDIAN_W-1:0]    median,
    input  logic [fre_pkg::STRIP_W-1:0]     strip_bits,
    output fre_pkg::fre_cw_t                cw,
    output logic                            cw_push,
    input  logic                            cw_full
);

    import fre_pkg::*;

    localparam int RW = ((SAMPLE_BITS > MEDIAN_W) ? SAMPLE_BITS : MEDIAN_W) + 1;

    front_state_t            state_reg;
    front_state_t            state_next;
    logic [VAL_W-1:0]        val_reg;
    logic [VAL_W-1:0]        val_next;
    logic [CODE_W-1:0]       dig_reg;
    logic [CODE_W-1:0]       dig_next;
    logic [LEN_W-1:0]        len_reg;
    logic [LEN_W-1:0]        len_next;
    logic [PASS_W-1:0]       pass_reg;
    logic                    nocode_reg;
    logic                    flush_reg;
    logic                    accept;
    logic [SAMPLE_BITS-1:0]  shifted;
    logic [RW-1:0]           resid;
    logic [RW-1:0]           zz;
    logic                    nocode;
    logic                    last_pass;
    logic [LEN_W-1:0]        k;

    assign accept    = push && !full;
    assign shifted   = sample >> strip_bits;
    assign resid     = RW'(shifted) - RW'(median);
    // Negative residuals map to even codes, the rest to odd codes.
    assign zz        = resid[RW-1] ? ((RW'(0) - resid) << 1) : ((resid << 1) | RW'(1));
    assign nocode    = (int'(strip_bits) >= SAMPLE_BITS);
    assign last_pass = (pass_reg == PASS_W'(SCAN_PASSES - 1));

    // Greedy Zeckendorf search: eight digits per pass, highest weight first.
    always_comb
    begin
        val_next = val_reg;
        dig_next = dig_reg;
        len_next = len_reg;
        k        = '0;
        for (int j = 0; j < SCAN_LANES; j++)
        begin
            k = LEN_W'(FIB_N - 1 - j) - {pass_reg, 3'b000};
            if (val_next >= FIB_WEIGHT[k])
            begin
                dig_next[k] = 1'b1;
                val_next    = val_next - FIB_WEIGHT[k];
                if (len_next == '0)
                begin
                    len_next = k + LEN_W'(2);
                end
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        full       = 1'b1;
        cw_push    = 1'b0;
        unique case (state_reg)
            F_IDLE:
            begin
                full = 1'b0;
                if (push)
                begin
                    state_next = F_SCAN;
                end
            end
            F_SCAN:
            begin
                if (last_pass)
                begin
                    state_next = F_SEND;
                end
            end
            F_SEND:
            begin
                if (!cw_full)
                begin
                    cw_push    = 1'b1;
                    full       = 1'b0;
                    state_next = push ? F_SCAN : F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cw.flush = flush_reg;
        if (nocode_reg)
        begin
            cw.code = '0;
            cw.len  = '0;
        end
        else
        begin
            cw.code = dig_reg | (CODE_W'(1) << (len_reg - 1'b1));
            cw.len  = len_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            pass_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                pass_reg <= '0;
            end
            else if (state_reg == F_SCAN)
            begin
                pass_reg <= pass_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            val_reg    <= VAL_W'(zz);
            dig_reg    <= '0;
            len_reg    <= '0;
            nocode_reg <= nocode;
            flush_reg  <= flush;
        end
        else if (state_reg == F_SCAN)
        begin
            val_reg <= val_next;
            dig_reg <= dig_next;
            len_reg <= len_next;
        end
    end

endmodule

### sv/fre_pack.sv
module fre_pack (
    input  logic              clk,
    input  logic              rst_n,
    input  fre_pkg::fre_cw_t  cw,
    input  logic              cw_empty,
    output logic              cw_pop,
    output fre_pkg::fre_out_t ob,
    output logic              ob_push,
    input  logic              ob_full
);

    import fre_pkg::*;

    back_state_t       state_reg;
    back_state_t       state_next;
    logic [ACC_W-1:0]  acc_reg;
    logic [ACC_W-1:0]  acc_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              flush_reg;
    logic              flush_next;
    logic              full_byte;

    assign full_byte = (cnt_reg >= CNT_W'(BYTE_W));

    // Bits above the fill count are kept at zero, so a padded byte needs no mask.
    always_comb
    begin
        state_next = state_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        flush_next = flush_reg;
        cw_pop     = 1'b0;
        ob_push    = 1'b0;
        ob.data    = acc_reg[BYTE_W-1:0];
        ob.last    = 1'b0;
        unique case (state_reg)
            B_LOAD:
            begin
                if (!cw_empty)
                begin
                    cw_pop     = 1'b1;
                    acc_next   = acc_reg | (ACC_W'(cw.code) << cnt_reg);
                    cnt_next   = cnt_reg + cw.len;
                    flush_next = cw.flush;
                    state_next = B_EMIT;
                end
            end
            B_EMIT:
            begin
                if (full_byte)
                begin
                    ob.last = flush_reg && (cnt_reg == CNT_W'(BYTE_W));
                    if (!ob_full)
                    begin
                        ob_push  = 1'b1;
                        acc_next = acc_reg >> BYTE_W;
                        cnt_next = cnt_reg - CNT_W'(BYTE_W);
                    end
                end
                else if (flush_reg && (cnt_reg != '0))
                begin
                    ob.last = 1'b1;
                    if (!ob_full)
                    begin
                        ob_push    = 1'b1;
                        acc_next   = '0;
                        cnt_next   = '0;
                        state_next = B_LOAD;
                    end
                end
                else
                begin
                    state_next = B_LOAD;
                end
            end
            default:
            begin
                state_next = B_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_LOAD;
            acc_reg   <= '0;
            cnt_reg   <= '0;
            flush_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            flush_reg <= flush_next;
        end
    end

endmodule

### sv/fibonacci_residual_encoder.sv
// Each sample beat is shifted right by strip_bits, offset by median, zigzag mapped and
// Fibonacci coded, and the code bits are packed LSB first into bytes; a flush beat
// zero-pads any partial final byte and marks the final byte with last. The front end
// maps a sample as it is taken, runs the digit search at eight compare-and-subtract
// steps per cycle, and hands the finished codeword on, while the next sample is taken,
// once the two-entry queue behind it has room; it takes no new sample mid-search. The
// packer loads a codeword, then emits one byte per cycle while the four-entry result
// queue has room, and returns to loading after the last full byte or after the padded
// byte of a flush; results wait until popped. No clearing pass runs after reset.
module fibonacci_residual_encoder #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [SAMPLE_BITS-1:0]        sample,
    input  logic                          flush,
    input  logic                          push,
    output logic                          full,
    output logic [fre_pkg::BYTE_W-1:0]    byte_res,
    output logic                          last,
    output logic                          empty,
    input  logic                          pop,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fre_pkg::ADDR_W-1:0]    paddr,
    input  logic [fre_pkg::DATA_W-1:0]    pwdata,
    output logic [fre_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    import fre_pkg::*;

    logic [MEDIAN_W-1:0] median_reg;
    logic [STRIP_W-1:0]  strip_reg;
    logic                cfg_wr;
    logic                reg_sel;
    fre_cw_t             front_cw;
    fre_cw_t             back_cw;
    logic                mid_push;
    logic                mid_full;
    logic                mid_pop;
    logic                mid_empty;
    fre_out_t            pack_ob;
    fre_out_t            oq_dout;
    logic                oq_push;
    logic                oq_full;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = (reg_sel == REG_MEDIAN) ? DATA_W'(median_reg) : DATA_W'(strip_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            median_reg <= '0;
            strip_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            if (reg_sel == REG_MEDIAN)
            begin
                median_reg <= pwdata[MEDIAN_W-1:0];
            end
            else
            begin
                strip_reg <= pwdata[STRIP_W-1:0];
            end
        end
    end

    fre_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample     (sample),
        .flush      (flush),
        .push       (push),
        .full       (full),
        .median     (median_reg),
        .strip_bits (strip_reg),
        .cw         (front_cw),
        .cw_push    (mid_push),
        .cw_full    (mid_full)
    );

    fre_fifo #(
        .WIDTH ($bits(fre_cw_t)),
        .AW    (1)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (mid_push),
        .din   (front_cw),
        .full  (mid_full),
        .rd_en (mid_pop),
        .dout  (back_cw),
        .empty (mid_empty)
    );

    fre_pack u_pack (
        .clk      (clk),
        .rst_n    (rst_n),
        .cw       (back_cw),
        .cw_empty (mid_empty),
        .cw_pop   (mid_pop),
        .ob       (pack_ob),
        .ob_push  (oq_push),
        .ob_full  (oq_full)
    );

    fre_fifo #(
        .WIDTH ($bits(fre_out_t)),
        .AW    (2)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (oq_push),
        .din   (pack_ob),
        .full  (oq_full),
        .rd_en (pop),
        .dout  (oq_dout),
        .empty (empty)
    );

    assign byte_res = oq_dout.data;
    assign last     = oq_dout.last;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full) |=> full)
        else $error("front end took a second sample during a digit search");

    a_mid_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(mid_push && mid_full))
        else $error("codeword handed on while the middle queue was full");

    a_out_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(oq_push && oq_full))
        else $error("byte written while the result queue was full");

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        mid_push |-> (front_cw.len <= LEN_W'(CODE_W)))
        else $error("codeword length exceeds the code width");

endmodule
